>>> hw/rtl/rhsv_pkg.sv
package rhsv_pkg;

	localparam int CHAN_W      = 8;
	localparam int HUE_W       = 15;
	localparam int HNUM_W      = 20;   // 3840 * 255 fits in 20 bits
	localparam int SNUM_W      = 16;   // 255 * 255 fits in 16 bits
	localparam int RECIP_SHIFT = 28;
	localparam int RECIP_W     = RECIP_SHIFT + 1;   // 2^28 itself for a divisor of one
	localparam int HPROD_W     = HNUM_W + RECIP_W;
	localparam int SPROD_W     = SNUM_W + RECIP_W;

	localparam logic [HNUM_W-1:0] HUE_GREEN = HNUM_W'(7680);
	localparam logic [HNUM_W-1:0] HUE_BLUE  = HNUM_W'(15360);
	localparam logic [HNUM_W-1:0] HUE_FULL  = HNUM_W'(23040);

	typedef enum logic [1:0] {
		SEL_RED,
		SEL_GREEN,
		SEL_BLUE
	} hue_sel_t;

endpackage

>>> hw/rtl/rhsv_recip_rom.sv
module rhsv_recip_rom
	import rhsv_pkg::*;
(
	input  logic [CHAN_W-1:0]  den,
	output logic [RECIP_W-1:0] recip
);

	// ceil(2^RECIP_SHIFT / d), zero for d of zero
	logic [RECIP_W-1:0] recip_tbl [2**CHAN_W];

	for (genvar i = 0; i < 2**CHAN_W; i++) begin : g_tbl
		if (i == 0) begin : g_zero
			assign recip_tbl[i] = '0;
		end else begin : g_val
			localparam logic [63:0] NUM = (64'd1 << RECIP_SHIFT) + 64'(i) - 64'd1;
			localparam logic [63:0] QV  = NUM / 64'(i);
			assign recip_tbl[i] = QV[RECIP_W-1:0];
		end
	end

	assign recip = recip_tbl[den];

endmodule

>>> hw/rtl/rgb_to_hsv_converter.sv
// Pixel converter from 8-bit red, green, blue to hue, saturation and value, with
// alpha carried alongside. It takes one pixel every clock while in_stall is low
// and returns each result after the four register stages: channel compare,
// reciprocal lookup, multiply, and the final shift with hue offset. The
// two divisions are exact, done as a multiply by a rounded-up reciprocal from a
// 256-entry constant table. Hue is in 1/64 degree units (0..23039), saturation is
// floor(255*delta/max) and value is the largest channel. When out_stall is held
// the stages fill up behind the output register and in_stall rises only once
// every stage holds a pixel; nothing is dropped or repeated.
module rgb_to_hsv_converter
	import rhsv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,

	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CHAN_W-1:0] red_in,
	input  logic [CHAN_W-1:0] green_in,
	input  logic [CHAN_W-1:0] blue_in,
	input  logic [CHAN_W-1:0] alpha_in,

	output logic              out_valid,
	input  logic              out_stall,
	output logic [HUE_W-1:0]  hue_out,
	output logic [CHAN_W-1:0] saturation_out,
	output logic [CHAN_W-1:0] value_out,
	output logic [CHAN_W-1:0] alpha_out
);

	// stage valid bits and load enables
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic load_s1, load_s2, load_s3, load_s4;

	// a stage loads when it is empty or its content moves on this cycle
	assign load_s4  = !valid_s4 || !out_stall;
	assign load_s3  = !valid_s3 || load_s4;
	assign load_s2  = !valid_s2 || load_s3;
	assign load_s1  = !valid_s1 || load_s2;
	assign in_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (load_s1) valid_s1 <= in_valid;
			if (load_s2) valid_s2 <= valid_s1;
			if (load_s3) valid_s3 <= valid_s2;
			if (load_s4) valid_s4 <= valid_s3;
		end
	end

	// ---------------------------------------------------------------
	// stage 1: max, min, winning channel and the signed channel difference
	// ---------------------------------------------------------------
	logic [CHAN_W-1:0] mx_c, mn_c, pos_c, sub_c;
	hue_sel_t          sel_c;
	logic              neg_c;
	logic [CHAN_W-1:0] mag_c;

	always_comb begin
		// ties go to red, then green
		if (red_in >= green_in && red_in >= blue_in) begin
			sel_c = SEL_RED;
			mx_c  = red_in;
			pos_c = green_in;
			sub_c = blue_in;
		end else if (green_in >= blue_in) begin
			sel_c = SEL_GREEN;
			mx_c  = green_in;
			pos_c = blue_in;
			sub_c = red_in;
		end else begin
			sel_c = SEL_BLUE;
			mx_c  = blue_in;
			pos_c = red_in;
			sub_c = green_in;
		end
		mn_c = red_in;
		if (green_in < mn_c) mn_c = green_in;
		if (blue_in < mn_c)  mn_c = blue_in;
		// sign and magnitude of the difference feeding the hue sector
		neg_c = pos_c < sub_c;
		mag_c = neg_c ? (sub_c - pos_c) : (pos_c - sub_c);
	end

	logic [CHAN_W-1:0] mx_s1, delta_s1, mag_s1, alpha_s1;
	hue_sel_t          sel_s1;
	logic              neg_s1;

	always_ff @(posedge clk) begin
		if (load_s1) begin
			mx_s1    <= mx_c;
			delta_s1 <= mx_c - mn_c;
			mag_s1   <= mag_c;
			sel_s1   <= sel_c;
			neg_s1   <= neg_c;
			alpha_s1 <= alpha_in;
		end
	end

	// ---------------------------------------------------------------
	// stage 2: numerators and reciprocals of delta and max
	// ---------------------------------------------------------------
	logic [RECIP_W-1:0] hrec_c, srec_c;

	rhsv_recip_rom u_hue_rom (
		.den   (delta_s1),
		.recip (hrec_c)
	);

	rhsv_recip_rom u_sat_rom (
		.den   (mx_s1),
		.recip (srec_c)
	);

	logic [HNUM_W-1:0]  hnum_s2;
	logic [SNUM_W-1:0]  snum_s2;
	logic [RECIP_W-1:0] hrec_s2, srec_s2;
	logic [CHAN_W-1:0]  mx_s2, alpha_s2;
	hue_sel_t           sel_s2;
	logic               neg_s2;

	always_ff @(posedge clk) begin
		if (load_s2) begin
			// 3840 * mag as (mag << 12) - (mag << 8)
			hnum_s2  <= (HNUM_W'(mag_s1) << 12) - (HNUM_W'(mag_s1) << 8);
			// 255 * delta as (delta << 8) - delta
			snum_s2  <= (SNUM_W'(delta_s1) << 8) - SNUM_W'(delta_s1);
			hrec_s2  <= hrec_c;
			srec_s2  <= srec_c;
			mx_s2    <= mx_s1;
			sel_s2   <= sel_s1;
			neg_s2   <= neg_s1;
			alpha_s2 <= alpha_s1;
		end
	end

	// ---------------------------------------------------------------
	// stage 3: numerator times reciprocal
	// ---------------------------------------------------------------
	logic [HPROD_W-1:0] hprod_s3;
	logic [SPROD_W-1:0] sprod_s3;
	logic [CHAN_W-1:0]  mx_s3, alpha_s3;
	hue_sel_t           sel_s3;
	logic               neg_s3;

	always_ff @(posedge clk) begin
		if (load_s3) begin
			hprod_s3 <= HPROD_W'(hnum_s2) * HPROD_W'(hrec_s2);
			sprod_s3 <= SPROD_W'(snum_s2) * SPROD_W'(srec_s2);
			mx_s3    <= mx_s2;
			sel_s3   <= sel_s2;
			neg_s3   <= neg_s2;
			alpha_s3 <= alpha_s2;
		end
	end

	// ---------------------------------------------------------------
	// stage 4: quotients, hue sector offset, output register
	// ---------------------------------------------------------------
	// a grey pixel has zero numerators and picks red, so hue and saturation
	// come out zero with no extra test
	logic [HNUM_W-1:0] hq_c;
	logic [CHAN_W-1:0] sq_c;
	logic [HNUM_W-1:0] hue_c;

	assign hq_c = hprod_s3[RECIP_SHIFT +: HNUM_W];
	assign sq_c = sprod_s3[RECIP_SHIFT +: CHAN_W];

	always_comb begin
		unique case (sel_s3)
			SEL_RED:   hue_c = neg_s3 ? (HUE_FULL - hq_c) : hq_c;
			SEL_GREEN: hue_c = neg_s3 ? (HUE_GREEN - hq_c) : (HUE_GREEN + hq_c);
			SEL_BLUE:  hue_c = neg_s3 ? (HUE_BLUE - hq_c) : (HUE_BLUE + hq_c);
			default:   hue_c = '0;
		endcase
	end

	logic [HUE_W-1:0]  hue_s4;
	logic [CHAN_W-1:0] sat_s4, value_s4, alpha_s4;

	always_ff @(posedge clk) begin
		if (load_s4) begin
			hue_s4   <= hue_c[HUE_W-1:0];
			sat_s4   <= sq_c;
			value_s4 <= mx_s3;
			alpha_s4 <= alpha_s3;
		end
	end

	assign out_valid      = valid_s4;
	assign hue_out        = hue_s4;
	assign saturation_out = sat_s4;
	assign value_out      = value_s4;
	assign alpha_out      = alpha_s4;

endmodule
